FILE: hdl/acb_pkg.sv
// Shared constants, types and helpers for the Annex B codec sniffer.
`default_nettype none

package acb_pkg;

    // NAL units scored per payload, and the counter width that holds that count
    localparam int MAX_NALS = 8;
    localparam int CNT_W    = $clog2(MAX_NALS + 1);

    // Score accumulators
    localparam int           SCORE_W   = 6;
    localparam int           INC_W     = 3;
    localparam logic [SCORE_W-1:0] SCORE_MAX = '1;

    // Reported NAL count saturates at the output field's full scale
    localparam int           SEEN_W    = 4;
    localparam logic [7:0]   SEEN_MAX  = 8'd15;

    // Byte position in the payload saturates here
    localparam logic [2:0]   POS_SAT   = 3'd4;
    localparam logic [2:0]   POS_LEAD3 = 3'd2;
    localparam logic [2:0]   POS_LEAD4 = 3'd3;

    // Distance from the last start code; saturated before any NAL and again once far from one
    localparam logic [2:0]   DIST_SAT  = 3'd7;
    localparam logic [2:0]   DIST_MIN  = 3'd3;

    // Byte values of interest
    localparam logic [7:0]   BYTE_ZERO = 8'h00;
    localparam logic [7:0]   BYTE_ONE  = 8'h01;
    localparam logic [7:0]   JPEG_FF   = 8'hFF;
    localparam logic [7:0]   JPEG_SOI  = 8'hD8;

    // H.264 NAL unit types
    localparam logic [4:0] AVC_SLICE = 5'd1;
    localparam logic [4:0] AVC_IDR   = 5'd5;
    localparam logic [4:0] AVC_SEI   = 5'd6;
    localparam logic [4:0] AVC_SPS   = 5'd7;
    localparam logic [4:0] AVC_PPS   = 5'd8;
    localparam logic [4:0] AVC_AUD   = 5'd9;

    // H.265 NAL unit types
    localparam logic [5:0] HEVC_TRAIL_N    = 6'd0;
    localparam logic [5:0] HEVC_TRAIL_R    = 6'd1;
    localparam logic [5:0] HEVC_IDR_W_RADL = 6'd19;
    localparam logic [5:0] HEVC_IDR_N_LP   = 6'd20;
    localparam logic [5:0] HEVC_CRA        = 6'd21;
    localparam logic [5:0] HEVC_VPS        = 6'd32;
    localparam logic [5:0] HEVC_SPS        = 6'd33;
    localparam logic [5:0] HEVC_PPS        = 6'd34;
    localparam logic [5:0] HEVC_PREFIX_SEI = 6'd39;
    localparam logic [5:0] HEVC_SUFFIX_SEI = 6'd40;

    // Score weights
    localparam logic [INC_W-1:0] INC_NONE  = 3'd0;
    localparam logic [INC_W-1:0] INC_WEAK  = 3'd1;
    localparam logic [INC_W-1:0] INC_KEY   = 3'd4;
    localparam logic [INC_W-1:0] INC_PARAM = 3'd5;

    typedef enum logic [1:0] {
        CODEC_UNKNOWN = 2'd0,
        CODEC_AVC     = 2'd1,
        CODEC_HEVC    = 2'd2
    } t_codec;

    // Score increments for one NAL header
    typedef struct packed {
        logic [INC_W-1:0] avc_inc;
        logic [INC_W-1:0] hevc_inc;
    } t_score_inc;

    // Saturating score add
    function automatic logic [SCORE_W-1:0] sat_add(input logic [SCORE_W-1:0] a,
                                                    input logic [INC_W-1:0]   b);
        logic [SCORE_W:0] s;
        s = {1'b0, a} + {{(SCORE_W + 1 - INC_W){1'b0}}, b};
        return s[SCORE_W] ? SCORE_MAX : s[SCORE_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: hdl/acb_nal_scorer.sv
// NAL header scorer: H.264 and H.265 type weights for one NAL unit header.
`default_nettype none

module acb_nal_scorer (
    input  logic [7:0]          i_first,
    input  logic                i_has_second,
    input  logic [7:0]          i_second,
    output acb_pkg::t_score_inc o_inc
);
    import acb_pkg::*;

    logic [4:0]       t264;
    logic [5:0]       t265;
    logic             hdr_ok;
    logic [INC_W-1:0] avc_inc;
    logic [INC_W-1:0] hevc_inc;

    assign t264 = i_first[4:0];
    assign t265 = i_first[6:1];

    // Two-byte H.265 header: forbidden bit and layer MSB clear, temporal id plus one nonzero
    assign hdr_ok = i_has_second && !i_first[7] && !i_first[0] && (i_second[2:0] != 3'd0);

    // H.264 weight
    always_comb begin
        case (t264)
            AVC_SPS, AVC_PPS, AVC_IDR:   avc_inc = INC_KEY;
            AVC_SLICE, AVC_SEI, AVC_AUD: avc_inc = INC_WEAK;
            default:                     avc_inc = INC_NONE;
        endcase
    end

    // H.265 weight, only with a valid header
    always_comb begin
        hevc_inc = INC_NONE;
        if (hdr_ok) begin
            case (t265)
                HEVC_VPS, HEVC_SPS, HEVC_PPS:              hevc_inc = INC_PARAM;
                HEVC_IDR_W_RADL, HEVC_IDR_N_LP, HEVC_CRA:  hevc_inc = INC_KEY;
                HEVC_TRAIL_N, HEVC_TRAIL_R,
                HEVC_PREFIX_SEI, HEVC_SUFFIX_SEI:          hevc_inc = INC_WEAK;
                default:                                   hevc_inc = INC_NONE;
            endcase
        end
    end

    assign o_inc.avc_inc  = avc_inc;
    assign o_inc.hevc_inc = hevc_inc;

endmodule

`default_nettype wire

FILE: hdl/annexb_codec_sniffer.sv
// Top level of the Annex B codec sniffer: start code scan, scoring, result word.
//
//  channel | direction | handshake                 | word
//  --------+-----------+---------------------------+----------------------------------------
//  input   | in        | i_in_valid / o_in_ready   | i_payload_byte, i_last_byte
//  result  | out       | o_out_valid / i_out_ready | o_codec, o_jpeg_start, o_avc_score,
//          |           |                           | o_hevc_score, o_nals_seen
//
//  One byte per cycle while the input is not stalled: a byte lands in the input register, and
//  the scan state is updated from it as it leaves there. A last byte loads the result register as it leaves.
//  Reset (synchronous, active low) clears the scan state and both valid flags.
//  Only a last byte waiting behind an untaken result stalls the input; other bytes flow on.
`default_nettype none

module annexb_codec_sniffer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_payload_byte,
    input  logic       i_last_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [1:0] o_codec,
    output logic       o_jpeg_start,
    output logic [5:0] o_avc_score,
    output logic [5:0] o_hevc_score,
    output logic [3:0] o_nals_seen
);
    import acb_pkg::*;

    // Input register
    logic       r_in_valid, n_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // Scan state
    logic [23:0]        r_hist,   n_hist;
    logic [2:0]         r_pos,    n_pos;
    logic [2:0]         r_dist,   n_dist;
    logic               r_pend_v, n_pend_v;
    logic [7:0]         r_pend_b, n_pend_b;
    logic               r_lead,   n_lead;
    logic               r_jpeg,   n_jpeg;
    logic [SCORE_W-1:0] r_avc,    n_avc;
    logic [SCORE_W-1:0] r_hevc,   n_hevc;
    logic [CNT_W-1:0]   r_cnt,    n_cnt;

    // Result register
    logic               r_out_valid, n_out_valid;
    t_codec             r_codec;
    logic               r_jpeg_o;
    logic [SCORE_W-1:0] r_avc_o, r_hevc_o;
    logic [SEEN_W-1:0]  r_seen_o;

    logic       adv;
    logic [7:0] b, h1, h2, h3;
    logic       score_en;
    logic [7:0] score_first;
    t_score_inc inc;
    logic       found;
    logic       lead_now, jpeg_now;
    logic [SCORE_W-1:0] avc_upd, hevc_upd;
    logic [CNT_W-1:0]   cnt_upd;
    logic [7:0]         cnt_ext;
    t_codec             codec_now;

    // The held byte moves on unless it is a last byte and the result slot is full and not being taken
    assign adv        = r_in_valid && (!r_in_last || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || adv;

    assign b  = r_in_byte;
    assign h1 = r_hist[7:0];
    assign h2 = r_hist[15:8];
    assign h3 = r_hist[23:16];

    // Header byte: scored right away on a last byte, else paired with the next byte
    assign score_en    = (r_dist == 3'd0) ? r_in_last : r_pend_v;
    assign score_first = (r_dist == 3'd0) ? b : r_pend_b;

    acb_nal_scorer u_scorer (
        .i_first      (score_first),
        .i_has_second (r_dist != 3'd0),
        .i_second     (b),
        .o_inc        (inc)
    );

    // Updated totals including this byte's header
    assign avc_upd  = score_en ? sat_add(r_avc, inc.avc_inc) : r_avc;
    assign hevc_upd = score_en ? sat_add(r_hevc, inc.hevc_inc) : r_hevc;
    assign cnt_upd  = score_en ? r_cnt + CNT_W'(1) : r_cnt;
    assign cnt_ext  = 8'(cnt_upd);

    // Leading start code and JPEG marker at the payload head
    assign lead_now = r_lead
        || ((r_pos == POS_LEAD3) && (h2 == BYTE_ZERO) && (h1 == BYTE_ZERO) && (b == BYTE_ONE))
        || ((r_pos == POS_LEAD4) && (h3 == BYTE_ZERO) && (h2 == BYTE_ZERO)
            && (h1 == BYTE_ZERO) && (b == BYTE_ONE));
    assign jpeg_now = r_jpeg
        || ((r_pos == POS_LEAD3) && (h2 == JPEG_FF) && (h1 == JPEG_SOI) && (b == JPEG_FF));

    // Start code that opens a new NAL unit
    assign found = (r_pos >= POS_LEAD3) && (r_dist >= DIST_MIN) && (h2 == BYTE_ZERO)
                   && (h1 == BYTE_ZERO) && (b == BYTE_ONE)
                   && (32'(cnt_upd) < 32'(MAX_NALS));

    // Codec decision
    always_comb begin
        codec_now = CODEC_UNKNOWN;
        if (lead_now) begin
            if (hevc_upd > avc_upd) begin
                codec_now = CODEC_HEVC;
            end else if (avc_upd > hevc_upd) begin
                codec_now = CODEC_AVC;
            end
        end
    end

    // Next scan state and valid flags
    always_comb begin
        n_in_valid = r_in_valid;
        if (o_in_ready) begin
            n_in_valid = i_in_valid;
        end

        n_hist   = r_hist;
        n_pos    = r_pos;
        n_dist   = r_dist;
        n_pend_v = r_pend_v;
        n_pend_b = r_pend_b;
        n_lead   = r_lead;
        n_jpeg   = r_jpeg;
        n_avc    = r_avc;
        n_hevc   = r_hevc;
        n_cnt    = r_cnt;
        if (adv) begin
            if (r_in_last) begin
                // payload done: back to the idle scan state
                n_hist   = '0;
                n_pos    = '0;
                n_dist   = DIST_SAT;
                n_pend_v = 1'b0;
                n_pend_b = '0;
                n_lead   = 1'b0;
                n_jpeg   = 1'b0;
                n_avc    = '0;
                n_hevc   = '0;
                n_cnt    = '0;
            end else begin
                n_hist = {r_hist[15:0], b};
                n_pos  = (r_pos < POS_SAT) ? r_pos + 3'd1 : r_pos;
                if (found) begin
                    n_dist = 3'd0;
                end else begin
                    n_dist = (r_dist == DIST_SAT) ? DIST_SAT : r_dist + 3'd1;
                end
                if (r_dist == 3'd0) begin
                    n_pend_v = 1'b1;
                    n_pend_b = b;
                end else if (r_pend_v) begin
                    n_pend_v = 1'b0;
                    n_pend_b = '0;
                end
                n_lead = lead_now;
                n_jpeg = jpeg_now;
                n_avc  = avc_upd;
                n_hevc = hevc_upd;
                n_cnt  = cnt_upd;
            end
        end

        n_out_valid = r_out_valid;
        if (adv && r_in_last) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    // Control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_hist      <= '0;
            r_pos       <= '0;
            r_dist      <= DIST_SAT;
            r_pend_v    <= 1'b0;
            r_pend_b    <= '0;
            r_lead      <= 1'b0;
            r_jpeg      <= 1'b0;
            r_avc       <= '0;
            r_hevc      <= '0;
            r_cnt       <= '0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            r_hist      <= n_hist;
            r_pos       <= n_pos;
            r_dist      <= n_dist;
            r_pend_v    <= n_pend_v;
            r_pend_b    <= n_pend_b;
            r_lead      <= n_lead;
            r_jpeg      <= n_jpeg;
            r_avc       <= n_avc;
            r_hevc      <= n_hevc;
            r_cnt       <= n_cnt;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (o_in_ready) begin
            r_in_byte <= i_payload_byte;
            r_in_last <= i_last_byte;
        end
        if (adv && r_in_last) begin
            r_codec  <= codec_now;
            r_jpeg_o <= jpeg_now;
            r_avc_o  <= avc_upd;
            r_hevc_o <= hevc_upd;
            r_seen_o <= (cnt_ext > SEEN_MAX) ? SEEN_MAX[SEEN_W-1:0] : cnt_ext[SEEN_W-1:0];
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_codec      = r_codec;
    assign o_jpeg_start = r_jpeg_o;
    assign o_avc_score  = r_avc_o;
    assign o_hevc_score = r_hevc_o;
    assign o_nals_seen  = r_seen_o;

    // Checks
    a_cnt_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_cnt) <= 32'(MAX_NALS))
        else $error("NAL count beyond limit");

    a_pend_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_v |-> (r_dist == 3'd1))
        else $error("pending header without a fresh start code");

    a_pos_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_SAT)
        else $error("payload position past saturation");

    a_last_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_in_last) |=> o_out_valid && (r_pos == 3'd0) && !r_lead)
        else $error("last byte did not load a result and clear the scan");

endmodule

`default_nettype wire
